>>> rtl/grid_ray_caster_top_macros.svh
// Assertion macros used by the grid ray caster controller.
// Needs clk and rst in the scope of each use.
`ifndef GRID_RAY_CASTER_TOP_MACROS_SVH
`define GRID_RAY_CASTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grc assertion failed");
`define GRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grc assertion failed");
`else
`define GRC_ASSERT_IMP(lbl, ante, cons)
`define GRC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/grc_pkg.sv
// Grid ray caster package: item types, register indexes, reset values,
// and the command/status structs between controller and datapath.
`timescale 1ns / 1ps
package grc_pkg;
  localparam int MAP_SIZE_DEF     = 64;
  localparam int SCREEN_WIDTH_DEF = 1024;
  localparam int CFG_W            = 22;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYER_X,
    REG_PLAYER_Y,
    REG_DIR_X,
    REG_DIR_Y,
    REG_PLANE_X,
    REG_PLANE_Y
  } reg_idx_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [21:0] PLAYER_RST  = 22'd0;
  localparam logic [15:0] DIR_X_RST   = 16'd16384;
  localparam logic [15:0] DIR_Y_RST   = 16'd0;
  localparam logic [15:0] PLANE_X_RST = 16'd0;
  localparam logic [15:0] PLANE_Y_RST = 16'd10813;
  localparam logic [23:0] DIST_MAX    = 24'hFFFFFF;

  typedef struct packed {
    logic       op;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] cell_value;
    logic [9:0] column;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic        cross_side;
    logic [23:0] perp_distance;
    logic [5:0]  wall_x;
    logic [5:0]  wall_y;
    logic [7:0]  wall_value;
    logic        escaped;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic mem_we;
    logic load_cast;
    logic calc_ray;
    logic init_walk;
    logic step;
    logic test;
    logic div_prep;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic start_out;
    logic step_out;
    logic hit;
    logic guard_last;
    logic div_last;
  } status_t;
endpackage

>>> rtl/grc_stream_if.sv
// Valid/ready stream channel carrying one payload of type T per beat.
// Used for the item and result channels of the grid ray caster.
`timescale 1ns / 1ps
interface grc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/grid_ray_caster_top.sv
// Grid ray caster top: DDA ray casting over a MAP_SIZE^2 map of 8-bit cells.
// Cell write: stored in the cycle it is accepted, no result. Cast: ray setup
// (S_RAY, S_INIT), a step and a map test (S_STEP, S_TEST) per DDA step until a
// hit or an exit, then the divide (S_DPREP, S_DIV) and the result load (S_DONE).
// One item at a time; the result register lets the next item in while the
// last result waits. After reset all MAP_SIZE^2 cells are swept to zero first.
`timescale 1ns / 1ps
module grid_ray_caster_top #(
  parameter int MAP_SIZE     = grc_pkg::MAP_SIZE_DEF,
  parameter int SCREEN_WIDTH = grc_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [grc_pkg::CFG_W-1:0]     cfg_data,
  grc_stream_if.sink                    item,
  grc_stream_if.source                  result
);
  import grc_pkg::*;

  cmd_t      cmd;
  status_t   status;
  out_item_t res;

  grc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_op     (item.data.op),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  grc_datapath #(
    .MAP_SIZE     (MAP_SIZE),
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_data  (item.data),
    .cmd      (cmd),
    .status   (status),
    .result   (res)
  );

  assign result.data = res;
endmodule

>>> rtl/grc_datapath.sv
// Grid ray caster datapath: config registers, map memory, ray setup,
// DDA stepping and the bit-serial distance divider. Uses grc_pkg.
`timescale 1ns / 1ps
module grc_datapath #(
  parameter int MAP_SIZE     = grc_pkg::MAP_SIZE_DEF,
  parameter int SCREEN_WIDTH = grc_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [grc_pkg::CFG_W-1:0]      cfg_data,
  input  grc_pkg::in_item_t              in_data,
  input  grc_pkg::cmd_t                  cmd,
  output grc_pkg::status_t               status,
  output grc_pkg::out_item_t             result
);
  import grc_pkg::*;

  localparam int MB         = $clog2(MAP_SIZE);
  localparam int PW         = ((MB > 6) ? MB : 6) + 2;
  localparam int DEPTH      = MAP_SIZE * MAP_SIZE;
  localparam int AW         = $clog2(DEPTH);
  localparam int NW         = $clog2(2 * MAP_SIZE + 5);
  localparam int GUARD_LAST = 2 * MAP_SIZE + 3;
  localparam int CAM_SPAN   = (SCREEN_WIDTH > 2046) ? SCREEN_WIDTH : 2046;
  localparam int CAMW       = $clog2(CAM_SPAN + 1) + 1;
  localparam int AXW        = 16 + $clog2(CAM_SPAN + 1);
  localparam int RXW        = AXW + 1;
  localparam int FW         = 17;
  localparam int ACCW       = AXW + FW + NW;
  localparam int LW         = FW + NW;
  localparam int SWW        = $clog2(SCREEN_WIDTH + 1);
  localparam int PRW        = LW + SWW;
  localparam int DW         = PRW + 14;
  localparam int DCW        = $clog2(DW);

  localparam logic signed [RXW-1:0] SW_S = RXW'(SCREEN_WIDTH);
  localparam logic [SWW-1:0]        SWV  = SWW'(SCREEN_WIDTH);
  localparam logic signed [PW-1:0]  MS_S = PW'(MAP_SIZE);

  logic [21:0]        px, py;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;

  logic [7:0]         mem [DEPTH];
  logic [AW-1:0]      clr_cnt;
  logic [7:0]         rdata;
  logic [AW-1:0]      waddr, raddr;
  logic               w_in_map;

  logic [9:0]             col;
  logic signed [CAMW-1:0] cam;
  logic signed [RXW-1:0]  rx, ry;
  logic [AXW-1:0]         ax, ay, ax_c, ay_c;
  logic [FW-1:0]          fx, fy, fx_c, fy_c;
  logic                   xneg, yneg;
  logic signed [PW-1:0]   mx, my, mx_new, my_new;
  logic [NW-1:0]          nx, ny, guard;
  logic [ACCW-1:0]        sidex, sidey;
  logic                   take_x;
  logic                   side, esc;
  logic [7:0]             wval;

  logic [LW-1:0]   along_c;
  logic [PRW-1:0]  prod_c;
  logic [DW-1:0]   dvd;
  logic [AXW-1:0]  dsr, rem;
  logic [AXW:0]    rem_sh;
  logic            ge;
  logic [23:0]     quo;
  logic            ovf;
  logic [DCW-1:0]  dcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      px      <= PLAYER_RST;
      py      <= PLAYER_RST;
      dir_x   <= DIR_X_RST;
      dir_y   <= DIR_Y_RST;
      plane_x <= PLANE_X_RST;
      plane_y <= PLANE_Y_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PLAYER_X: px      <= cfg_data;
        REG_PLAYER_Y: py      <= cfg_data;
        REG_DIR_X:    dir_x   <= cfg_data[15:0];
        REG_DIR_Y:    dir_y   <= cfg_data[15:0];
        REG_PLANE_X:  plane_x <= cfg_data[15:0];
        REG_PLANE_Y:  plane_y <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // map memory: one write port (clear sweep or cell write), one read port
  assign w_in_map = (32'(in_data.cell_x) < MAP_SIZE) && (32'(in_data.cell_y) < MAP_SIZE);
  assign waddr = AW'(32'(in_data.cell_x) * MAP_SIZE + 32'(in_data.cell_y));
  assign raddr = AW'(32'(mx_new[PW-2:0]) * MAP_SIZE + 32'(my_new[PW-2:0]));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt] <= 8'h00;
    end else if (cmd.mem_we && w_in_map) begin
      mem[waddr] <= in_data.cell_value;
    end
    if (cmd.step) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // ray setup
  assign ax_c = AXW'(rx[RXW-1] ? -rx : rx);
  assign ay_c = AXW'(ry[RXW-1] ? -ry : ry);
  assign fx_c = rx[RXW-1] ? {1'b0, px[15:0]} : 17'h10000 - {1'b0, px[15:0]};
  assign fy_c = ry[RXW-1] ? {1'b0, py[15:0]} : 17'h10000 - {1'b0, py[15:0]};

  // DDA step decision
  assign take_x = (ax != '0) && ((ay == '0) || (sidex < sidey));
  assign mx_new = take_x ? (xneg ? mx - PW'(1) : mx + PW'(1)) : mx;
  assign my_new = take_x ? my : (yneg ? my - PW'(1) : my + PW'(1));

  // divider operands
  assign along_c = side ? LW'(fy) + LW'({ny - NW'(1), 16'h0000})
                        : LW'(fx) + LW'({nx - NW'(1), 16'h0000});
  assign prod_c  = PRW'(along_c) * PRW'(SWV);
  assign rem_sh  = {rem, dvd[DW-1]};
  assign ge      = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (cmd.load_cast) begin
      col <= in_data.column;
      cam <= $signed(CAMW'({in_data.column, 1'b0})) - $signed(CAMW'(SCREEN_WIDTH));
    end
    if (cmd.calc_ray) begin
      rx <= RXW'(dir_x) * SW_S + RXW'(plane_x) * RXW'(cam);
      ry <= RXW'(dir_y) * SW_S + RXW'(plane_y) * RXW'(cam);
    end
    if (cmd.init_walk) begin
      ax    <= ax_c;
      ay    <= ay_c;
      fx    <= fx_c;
      fy    <= fy_c;
      xneg  <= rx[RXW-1];
      yneg  <= ry[RXW-1];
      mx    <= PW'(px[21:16]);
      my    <= PW'(py[21:16]);
      sidex <= ACCW'(fx_c) * ACCW'(ay_c);
      sidey <= ACCW'(fy_c) * ACCW'(ax_c);
      nx    <= '0;
      ny    <= '0;
      guard <= '0;
      side  <= 1'b0;
      wval  <= 8'h00;
      esc   <= status.start_out;
    end
    if (cmd.step) begin
      mx  <= mx_new;
      my  <= my_new;
      esc <= status.step_out;
      if (take_x) begin
        nx    <= nx + NW'(1);
        sidex <= sidex + ACCW'({ay, 16'h0000});
        side  <= 1'b0;
      end else begin
        ny    <= ny + NW'(1);
        sidey <= sidey + ACCW'({ax, 16'h0000});
        side  <= 1'b1;
      end
    end
    if (cmd.test) begin
      wval  <= rdata;
      guard <= guard + NW'(1);
      esc   <= (rdata == 8'h00) && status.guard_last;
    end
    if (cmd.div_prep) begin
      dvd  <= {prod_c, 14'h0000};
      dsr  <= side ? ay : ax;
      rem  <= '0;
      quo  <= '0;
      ovf  <= 1'b0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? AXW'(rem_sh - {1'b0, dsr}) : AXW'(rem_sh);
      ovf  <= ovf | quo[23];
      quo  <= {quo[22:0], ge};
      dvd  <= {dvd[DW-2:0], 1'b0};
      dcnt <= dcnt + DCW'(1);
    end
    if (cmd.out_load) begin
      result.out_column <= col;
      if (esc) begin
        result.cross_side    <= 1'b0;
        result.perp_distance <= '0;
        result.wall_x        <= '0;
        result.wall_y        <= '0;
        result.wall_value    <= '0;
        result.escaped       <= 1'b1;
      end else begin
        result.cross_side    <= side;
        result.perp_distance <= ovf ? DIST_MAX : quo;
        result.wall_x        <= mx[5:0];
        result.wall_y        <= my[5:0];
        result.wall_value    <= wval;
        result.escaped       <= 1'b0;
      end
    end
  end

  always_comb begin
    status.clear_last = clr_cnt == AW'(DEPTH - 1);
    status.start_out  = (32'(px[21:16]) >= MAP_SIZE) || (32'(py[21:16]) >= MAP_SIZE);
    status.step_out   = (mx_new < 0) || (mx_new >= MS_S) || (my_new < 0) || (my_new >= MS_S);
    status.hit        = rdata != 8'h00;
    status.guard_last = guard == NW'(GUARD_LAST);
    status.div_last   = dcnt == DCW'(DW - 1);
  end
endmodule

>>> rtl/grc_controller.sv
// Grid ray caster controller: map clear sweep, item handshake, cast
// sequencing and the result register valid. Uses grc_pkg and the macros.
`timescale 1ns / 1ps
`include "grid_ray_caster_top_macros.svh"
module grc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output grc_pkg::cmd_t    cmd,
  input  grc_pkg::status_t status
);
  import grc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RAY,
    S_INIT,
    S_STEP,
    S_TEST,
    S_DPREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.clear     = state == S_CLEAR;
    cmd.mem_we    = (state == S_IDLE) && in_valid && (in_op == OP_WRITE);
    cmd.load_cast = (state == S_IDLE) && in_valid && (in_op == OP_CAST);
    cmd.calc_ray  = state == S_RAY;
    cmd.init_walk = state == S_INIT;
    cmd.step      = state == S_STEP;
    cmd.test      = state == S_TEST;
    cmd.div_prep  = state == S_DPREP;
    cmd.div_step  = state == S_DIV;
    cmd.out_load  = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (status.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.load_cast) state <= S_RAY;
        end
        S_RAY:   state <= S_INIT;
        S_INIT:  state <= status.start_out ? S_DONE : S_STEP;
        S_STEP:  state <= status.step_out ? S_DONE : S_TEST;
        S_TEST: begin
          if (status.hit) state <= S_DPREP;
          else if (status.guard_last) state <= S_DONE;
          else state <= S_STEP;
        end
        S_DPREP: state <= S_DIV;
        S_DIV: begin
          if (status.div_last) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GRC_ASSERT_NXT(a_step_to_test, (state == S_STEP) && !status.step_out, state == S_TEST)
  `GRC_ASSERT_NXT(a_div_done, (state == S_DIV) && status.div_last, state == S_DONE)
  `GRC_ASSERT_NXT(a_load_sets_valid, cmd.out_load, out_valid && (state == S_IDLE))
endmodule
